### hdl/asw_pkg.sv
// Shared widths, codes and the item sideband type for the saturation waveshaper.
package asw_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int SAMPLE_FRAC = 23;
    localparam int GAIN_W      = 24;
    localparam int GAIN_FRAC   = 14;
    localparam int MIX_W       = 7;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // drive product and driven magnitude (Q.23, below 2^33)
    localparam int PROD_W = SAMPLE_W + GAIN_W;
    localparam int M_W    = 33;

    // x/(1+|x|) quotient chain
    localparam int Q_W   = 24;
    localparam int DEN_W = M_W + 1;
    localparam int NUM_W = M_W + SAMPLE_FRAC + 1;

    // dry/wet mix and divide by 100 through a reciprocal
    localparam int ACC_W     = 32;
    localparam int V_W       = 30;
    localparam int MIX_SHIFT = 38;
    localparam int RECIP_W   = 32;
    localparam int RP_W      = V_W + RECIP_W;

    localparam logic [SAMPLE_W-1:0] Q23_ONE    = 24'h800000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [PROD_W-1:0]   DRIVE_HALF = PROD_W'(1) << (GAIN_FRAC - 1);
    localparam logic [MIX_W-1:0]    MIX_FULL   = 7'd100;
    localparam logic [V_W-1:0]      MIX_HALF   = 30'd50;
    localparam logic [RECIP_W-1:0]  MIX_RECIP  =
        RECIP_W'(((64'd1 << MIX_SHIFT) + 64'd99) / 64'd100);

    localparam logic [GAIN_W-1:0] DRIVE_RESET  = 24'd16384;
    localparam logic [MIX_W-1:0]  MIX_RESET    = 7'd100;
    localparam logic              ENABLE_RESET = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TANH     = 2'd0,
        MODE_SOFT     = 2'd1,
        MODE_HARD     = 2'd2,
        MODE_TANH_ALT = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE  = 2'd0,
        CFG_MIX    = 2'd1,
        CFG_MODE   = 2'd2,
        CFG_ENABLE = 2'd3
    } cfg_idx_t;

    // what rides along with each item through the pipeline
    typedef struct packed {
        logic                       blk;
        logic signed [SAMPLE_W-1:0] sample;
    } asw_side_t;

endpackage

### hdl/asw_div.sv
// Pipelined restoring divider for the x/(1+|x|) curve, one quotient bit per stage.
module asw_div
    import asw_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid_in,
    input  asw_side_t      side_in,
    input  logic [M_W-1:0] m_in,
    output logic           valid_out,
    output asw_side_t      side_out,
    output logic [M_W-1:0] m_out,
    output logic [Q_W-1:0] quo_out
);

    logic [DEN_W-1:0] den_prep;
    logic [NUM_W-1:0] num_prep;

    logic [Q_W:0]     valid_reg;
    asw_side_t        side_reg [Q_W+1];
    logic [DEN_W-1:0] den_reg  [Q_W+1];
    logic [DEN_W-1:0] rem_reg  [Q_W+1];
    logic [Q_W-1:0]   low_reg  [Q_W+1];
    logic [Q_W-1:0]   quo_reg  [Q_W+1];

    logic [DEN_W:0]   trial    [Q_W];
    logic [DEN_W:0]   diff     [Q_W];
    logic [DEN_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   quo_next [Q_W];

    // numerator carries the rounding half of the denominator
    always_comb
    begin
        den_prep = DEN_W'(m_in) + DEN_W'(Q23_ONE);
        num_prep = NUM_W'({m_in, {SAMPLE_FRAC{1'b0}}}) + NUM_W'(den_prep >> 1);
    end

    always_comb
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            trial[k] = {rem_reg[k], low_reg[k][Q_W-1]};
            diff[k]  = trial[k] - {1'b0, den_reg[k]};
            if (!diff[k][DEN_W])
            begin
                rem_next[k] = diff[k][DEN_W-1:0];
                quo_next[k] = {quo_reg[k][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[k][DEN_W-1:0];
                quo_next[k] = {quo_reg[k][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[Q_W-1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        den_reg[0]  <= den_prep;
        rem_reg[0]  <= DEN_W'(num_prep[NUM_W-1:Q_W]);
        low_reg[0]  <= num_prep[Q_W-1:0];
        quo_reg[0]  <= '0;
        for (int k = 0; k < Q_W; k++)
        begin
            side_reg[k+1] <= side_reg[k];
            den_reg[k+1]  <= den_reg[k];
            rem_reg[k+1]  <= rem_next[k];
            low_reg[k+1]  <= {low_reg[k][Q_W-2:0], 1'b0};
            quo_reg[k+1]  <= quo_next[k];
        end
    end

    assign valid_out = valid_reg[Q_W];
    assign side_out  = side_reg[Q_W];
    assign m_out     = M_W'(den_reg[Q_W] - DEN_W'(Q23_ONE));
    assign quo_out   = quo_reg[Q_W];

endmodule

### hdl/asw_shape.sv
// Curve stages: interpolated tanh table, hard clip and curve select by mode.
module asw_shape
    import asw_pkg::*;
#(
    parameter int TANH_TABLE_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mode_t               mode,
    input  logic                valid_in,
    input  asw_side_t           side_in,
    input  logic [M_W-1:0]      m_in,
    input  logic [Q_W-1:0]      quo_in,
    output logic                valid_out,
    output asw_side_t           side_out,
    output logic [SAMPLE_W-1:0] y_out
);

    localparam int SPAN_LOG2    = 3;
    localparam int TAYLOR_TERMS = 24;
    localparam int TABLE_SIZE   = 1 << TANH_TABLE_BITS;
    localparam int SEG_SHIFT    = SAMPLE_FRAC + SPAN_LOG2 - TANH_TABLE_BITS;
    localparam int IDX_TOP      = SEG_SHIFT + TANH_TABLE_BITS;
    localparam int FP_W         = SAMPLE_W + SEG_SHIFT;
    localparam logic [63:0] Q30 = 64'd1 << 30;

    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[62:0], num[k]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (Q30 >> 1)) >> 30;
    endfunction

    // per-segment decay e^(-2*span/segments) in Q0.30
    function automatic logic [63:0] step_decay();
        logic [63:0]        s;
        logic [63:0]        term;
        logic [63:0]        nn;
        logic signed [63:0] sum;
        s    = 64'd1 << (31 + SPAN_LOG2 - TANH_TABLE_BITS);
        term = Q30;
        sum  = signed'(Q30);
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            nn   = 64'(n);
            term = long_div(term * s + (nn << 29), nn << 30);
            if (nn[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        return unsigned'(sum);
    endfunction

    function automatic logic [63:0] tanh_entry(input logic [63:0] c, input logic [63:0] idx);
        logic [63:0] r;
        logic [63:0] base;
        logic [63:0] num;
        logic [63:0] den;
        r    = Q30;
        base = c;
        for (int k = 0; k <= TANH_TABLE_BITS; k++)
        begin
            if (idx[k])
                r = mul_q30(r, base);
            base = mul_q30(base, base);
        end
        num = (Q30 - r) << SAMPLE_FRAC;
        den = Q30 + r;
        return long_div(num + (den >> 1), den);
    endfunction

    localparam logic [63:0] STEP_C      = step_decay();
    localparam logic [63:0] T_LAST_FULL = tanh_entry(STEP_C, 64'(TABLE_SIZE));
    localparam logic [SAMPLE_W-1:0] T_LAST = T_LAST_FULL[SAMPLE_W-1:0];

    logic [SAMPLE_W-1:0] base_rom  [TABLE_SIZE];
    logic [SAMPLE_W-1:0] delta_rom [TABLE_SIZE];

    for (genvar g = 0; g < TABLE_SIZE; g++)
    begin : g_rom
        localparam logic [63:0] LO = tanh_entry(STEP_C, 64'(g));
        localparam logic [63:0] HI = tanh_entry(STEP_C, 64'(g + 1));
        localparam logic [63:0] DL = (HI > LO) ? (HI - LO) : 64'd0;
        assign base_rom[g]  = LO[SAMPLE_W-1:0];
        assign delta_rom[g] = DL[SAMPLE_W-1:0];
    end

    logic [TANH_TABLE_BITS-1:0] idx;

    logic [2:0]              valid_reg;
    asw_side_t               side1_reg, side2_reg, side3_reg;
    logic [SAMPLE_W-1:0]     base1_reg, base2_reg;
    logic [SAMPLE_W-1:0]     delta1_reg;
    logic [SEG_SHIFT-1:0]    frac1_reg;
    logic                    over1_reg, over2_reg;
    logic [Q_W-1:0]          soft1_reg, soft2_reg;
    logic [SAMPLE_W-1:0]     hard1_reg, hard2_reg;
    logic [SAMPLE_W-1:0]     hard1_next;
    logic [FP_W-1:0]         fp2_reg;
    logic [FP_W-1:0]         fp2_next;
    logic [SAMPLE_W-1:0]     tanh_val;
    logic [SAMPLE_W-1:0]     y_reg;
    logic [SAMPLE_W-1:0]     y_next;

    assign idx        = m_in[SEG_SHIFT +: TANH_TABLE_BITS];
    assign hard1_next = (m_in > M_W'(Q23_ONE)) ? Q23_ONE : m_in[SAMPLE_W-1:0];
    assign fp2_next   = FP_W'(delta1_reg) * FP_W'(frac1_reg);

    // past the table span the curve stays at the last entry
    always_comb
    begin
        if (over2_reg)
            tanh_val = T_LAST;
        else
            tanh_val = base2_reg + fp2_reg[FP_W-1:SEG_SHIFT];
        unique case (mode)
            MODE_SOFT:     y_next = soft2_reg;
            MODE_HARD:     y_next = hard2_reg;
            MODE_TANH,
            MODE_TANH_ALT: y_next = tanh_val;
            default:       y_next = tanh_val;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg  <= side_in;
        base1_reg  <= base_rom[idx];
        delta1_reg <= delta_rom[idx];
        frac1_reg  <= m_in[SEG_SHIFT-1:0];
        over1_reg  <= |m_in[M_W-1:IDX_TOP];
        soft1_reg  <= quo_in;
        hard1_reg  <= hard1_next;

        side2_reg  <= side1_reg;
        base2_reg  <= base1_reg;
        over2_reg  <= over1_reg;
        soft2_reg  <= soft1_reg;
        hard2_reg  <= hard1_reg;
        fp2_reg    <= fp2_next;

        side3_reg  <= side2_reg;
        y_reg      <= y_next;
    end

    assign valid_out = valid_reg[2];
    assign side_out  = side3_reg;
    assign y_out     = y_reg;

endmodule

### hdl/audio_saturation_waveshaper.sv
// Saturation waveshaper top level: drive, curve, dry/wet mix and output register.
//
//  channel   ports                                        handshake
//  input     sample_in, block_end_in                      start, busy (always low)
//  result    sample_out, block_end_out                    done, one cycle per item
//  config    cfg_index, cfg_data                          cfg_write, no wait
//
// One item is taken every cycle. Every item passes through the 24-stage quotient
// chain of the x/(1+|x|) curve, whatever the mode, so that results keep their
// order.
// Reset clears the valid bits and loads the register defaults. The receiver
// cannot stall, so the pipeline never holds and busy stays low.
module audio_saturation_waveshaper
    import asw_pkg::*;
#(
    parameter int TANH_TABLE_BITS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       block_end_in,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       block_end_out,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic [GAIN_W-1:0] drive_gain_reg;
    logic [MIX_W-1:0]  mix_percent_reg;
    mode_t             shaper_mode_reg;
    logic              enabled_reg;

    logic [MIX_W-1:0]  wet_share;

    // front stages: magnitude, drive product, rounded driven magnitude
    logic                va_reg, vb_reg, vc_reg;
    asw_side_t           side_a_reg, side_b_reg, side_c_reg;
    logic [SAMPLE_W-1:0] mag_a_reg, mag_a_next;
    logic [PROD_W-1:0]   prod_b_reg, prod_b_next;
    logic [PROD_W-1:0]   drive_sum;
    logic [M_W-1:0]      m_c_reg, m_c_next;

    logic                div_valid;
    asw_side_t           div_side;
    logic [M_W-1:0]      div_m;
    logic [Q_W-1:0]      div_quo;

    logic                shp_valid;
    asw_side_t           shp_side;
    logic [SAMPLE_W-1:0] shp_y;

    // mix stages
    logic                    vd_reg, ve_reg;
    asw_side_t               side_d_reg, side_e_reg;
    logic signed [ACC_W-1:0] wet_ext, dry_ext, w_ext, dw_ext;
    logic signed [ACC_W-1:0] acc_d_reg, acc_d_next;
    logic [ACC_W-1:0]        acc_mag;
    logic [V_W-1:0]          rnd_val;
    logic [RP_W-1:0]         prod_e_reg, prod_e_next;
    logic                    neg_e_reg;
    logic [SAMPLE_W-1:0]     q_mag, q_sat;

    logic                       done_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic                       block_end_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_gain_reg  <= DRIVE_RESET;
            mix_percent_reg <= MIX_RESET;
            shaper_mode_reg <= MODE_TANH;
            enabled_reg     <= ENABLE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DRIVE:  drive_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_MIX:    mix_percent_reg <= cfg_data[MIX_W-1:0];
                CFG_MODE:   shaper_mode_reg <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_ENABLE: enabled_reg     <= cfg_data[0];
                default:    enabled_reg     <= enabled_reg;
            endcase
        end
    end

    assign busy      = 1'b0;
    assign wet_share = (mix_percent_reg > MIX_FULL) ? MIX_FULL : mix_percent_reg;

    assign mag_a_next  = sample_in[SAMPLE_W-1] ? (~unsigned'(sample_in) + SAMPLE_W'(1))
                                               : unsigned'(sample_in);
    assign prod_b_next = PROD_W'(mag_a_reg) * PROD_W'(drive_gain_reg);
    assign drive_sum   = prod_b_reg + DRIVE_HALF;
    assign m_c_next    = drive_sum[GAIN_FRAC +: M_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= start & ~busy;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vd_reg   <= shp_valid;
            ve_reg   <= vd_reg;
            done_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side_a_reg <= '{blk: block_end_in, sample: sample_in};
        mag_a_reg  <= mag_a_next;
        side_b_reg <= side_a_reg;
        prod_b_reg <= prod_b_next;
        side_c_reg <= side_b_reg;
        m_c_reg    <= m_c_next;
    end

    asw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (vc_reg),
        .side_in   (side_c_reg),
        .m_in      (m_c_reg),
        .valid_out (div_valid),
        .side_out  (div_side),
        .m_out     (div_m),
        .quo_out   (div_quo)
    );

    asw_shape #(
        .TANH_TABLE_BITS (TANH_TABLE_BITS)
    ) u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (shaper_mode_reg),
        .valid_in  (div_valid),
        .side_in   (div_side),
        .m_in      (div_m),
        .quo_in    (div_quo),
        .valid_out (shp_valid),
        .side_out  (shp_side),
        .y_out     (shp_y)
    );

    // give the curve output the sign of the input, then weight wet and dry
    always_comb
    begin
        if (shp_side.sample[SAMPLE_W-1])
            wet_ext = -signed'(ACC_W'(shp_y));
        else
            wet_ext = signed'(ACC_W'(shp_y));
        dry_ext    = ACC_W'(shp_side.sample);
        w_ext      = signed'(ACC_W'(wet_share));
        dw_ext     = signed'(ACC_W'(MIX_FULL - wet_share));
        acc_d_next = w_ext * wet_ext + dw_ext * dry_ext;
    end

    // round half away from zero, divide by 100 through the reciprocal
    always_comb
    begin
        acc_mag     = acc_d_reg[ACC_W-1] ? unsigned'(-acc_d_reg) : unsigned'(acc_d_reg);
        rnd_val     = acc_mag[V_W-1:0] + MIX_HALF;
        prod_e_next = RP_W'(rnd_val) * RP_W'(MIX_RECIP);
    end

    always_comb
    begin
        q_mag = prod_e_reg[MIX_SHIFT +: SAMPLE_W];
        if (neg_e_reg)
            q_sat = ~q_mag + SAMPLE_W'(1);
        else if (q_mag > SAMPLE_MAX)
            q_sat = SAMPLE_MAX;
        else
            q_sat = q_mag;
        sample_out_next = enabled_reg ? signed'(q_sat) : side_e_reg.sample;
    end

    always_ff @(posedge clk)
    begin
        side_d_reg        <= shp_side;
        acc_d_reg         <= acc_d_next;
        side_e_reg        <= side_d_reg;
        neg_e_reg         <= acc_d_reg[ACC_W-1];
        prod_e_reg        <= prod_e_next;
        sample_out_reg    <= sample_out_next;
        block_end_out_reg <= side_e_reg.blk;
    end

    assign done          = done_reg;
    assign sample_out    = sample_out_reg;
    assign block_end_out = block_end_out_reg;

endmodule

### test/asw_shape_checker.sv
// Checker for the saturation waveshaper: predicts each result and compares it.
module asw_shape_checker
    import asw_pkg::*;
#(
    parameter int TABLE_BITS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       block_end_in,
    input  logic                       done,
    input  logic signed [SAMPLE_W-1:0] sample_out,
    input  logic                       block_end_out,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         pending,
    output int                         fails,
    output int                         results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SPAN_LOG2    = 3;
    localparam int     SEG_SHIFT    = SAMPLE_FRAC + SPAN_LOG2 - TABLE_BITS;
    localparam int     TAB_LAST     = 1 << TABLE_BITS;
    localparam int     TAYLOR_TERMS = 24;
    localparam int     REPORT_MAX   = 25;
    localparam longint Q30_ONE      = longint'(1) << 30;
    localparam longint Q23          = longint'(1) << SAMPLE_FRAC;
    localparam longint DRIVE_ROUND  = longint'(1) << (GAIN_FRAC - 1);
    localparam longint PCT          = 100;
    localparam longint OUT_MAX      = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN      = -(longint'(1) << (SAMPLE_W - 1));

    logic [GAIN_W-1:0] drive_q;
    logic [MIX_W-1:0]  mix_q;
    mode_t             mode_q;
    logic              en_q;

    longint    tanh_tab [0:TAB_LAST];
    asw_side_t shaped_q[$];
    asw_side_t want;
    int        reported;

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + (Q30_ONE >> 1)) >> 30;
    endfunction

    // per-segment decay e^(-2*span/segments) in Q0.30, rounded Taylor series
    function automatic longint decay_step();
        longint s;
        longint term;
        longint sum;
        s = longint'(1) << (31 + SPAN_LOG2 - TABLE_BITS);
        term = Q30_ONE;
        sum = Q30_ONE;
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = (term * s + (longint'(n) << 29)) / (longint'(n) << 30);
            if (n % 2 == 1)
                sum -= term;
            else
                sum += term;
        end
        return sum;
    endfunction

    // tanh at segment boundary i: (1 - c^i) / (1 + c^i), power by squaring
    function automatic longint tanh_point(input longint c, input longint i);
        longint r;
        longint base;
        longint num;
        longint den;
        r = Q30_ONE;
        base = c;
        while (i != 0)
        begin
            if (i % 2 == 1)
                r = q30_mul(r, base);
            base = q30_mul(base, base);
            i = i >> 1;
        end
        num = (Q30_ONE - r) << SAMPLE_FRAC;
        den = Q30_ONE + r;
        return (num + (den >> 1)) / den;
    endfunction

    initial
    begin
        longint c;
        c = decay_step();
        for (int i = 0; i <= TAB_LAST; i++)
            tanh_tab[i] = tanh_point(c, i);
    end

    function automatic asw_side_t shape_sample(input logic [SAMPLE_W-1:0] raw, input logic blk);
        asw_side_t r;
        longint mag;
        longint x;
        longint m;
        longint y;
        longint a;
        longint b;
        longint seg;
        longint frac;
        longint wet;
        longint w;
        longint acc;
        longint q;
        r.blk = blk;
        r.sample = raw;
        if (!en_q)
            return r;
        mag = raw[SAMPLE_W-1] ? (longint'(1) << SAMPLE_W) - longint'(raw) : longint'(raw);
        x = raw[SAMPLE_W-1] ? -mag : mag;
        m = (mag * longint'(drive_q) + DRIVE_ROUND) >> GAIN_FRAC;
        case (mode_q)
            MODE_SOFT: y = ((m << SAMPLE_FRAC) + ((m + Q23) >> 1)) / (m + Q23);
            MODE_HARD: y = (m > Q23) ? Q23 : m;
            default:
            begin
                seg = m >> SEG_SHIFT;
                frac = m & ((longint'(1) << SEG_SHIFT) - 1);
                if (seg >= TAB_LAST)
                    y = tanh_tab[TAB_LAST];
                else
                begin
                    a = tanh_tab[seg];
                    b = tanh_tab[seg + 1];
                    if (b < a)
                        b = a;
                    y = a + (((b - a) * frac) >> SEG_SHIFT);
                end
            end
        endcase
        wet = raw[SAMPLE_W-1] ? -y : y;
        w = (mix_q > MIX_FULL) ? PCT : longint'(mix_q);
        acc = w * wet + (PCT - w) * x;
        // round half away from zero, then clamp to Q1.23
        if (acc >= 0)
            q = (acc + PCT / 2) / PCT;
        else
            q = -((-acc + PCT / 2) / PCT);
        if (q > OUT_MAX)
            q = OUT_MAX;
        if (q < OUT_MIN)
            q = OUT_MIN;
        r.sample = q[SAMPLE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_q <= DRIVE_RESET;
            mix_q <= MIX_RESET;
            mode_q <= MODE_TANH;
            en_q <= ENABLE_RESET;
            shaped_q.delete();
            pending <= 0;
            fails = 0;
            results = 0;
            reported = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DRIVE:  drive_q <= cfg_data[GAIN_W-1:0];
                    CFG_MIX:    mix_q <= cfg_data[MIX_W-1:0];
                    CFG_MODE:   mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
                    CFG_ENABLE: en_q <= cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                shaped_q.push_back(shape_sample(sample_in, block_end_in));
            if (done)
            begin
                if (shaped_q.size() == 0)
                begin
                    fails++;
                    if (reported < REPORT_MAX)
                        $display("%0t: result with no item pending: expected none, actual %0d/%b",
                                 $time, sample_out, block_end_out);
                    reported++;
                end
                else
                begin
                    want = shaped_q.pop_front();
                    results++;
                    if (sample_out !== want.sample)
                    begin
                        fails++;
                        if (reported < REPORT_MAX)
                            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                                     $time, want.sample, sample_out);
                        reported++;
                    end
                    if (block_end_out !== want.blk)
                    begin
                        fails++;
                        if (reported < REPORT_MAX)
                            $display("%0t: block_end_out mismatch: expected %b, actual %b",
                                     $time, want.blk, block_end_out);
                        reported++;
                    end
                end
            end
            pending <= shaped_q.size();
        end
    end

endmodule

### test/tb.sv
// Testbench top for the saturation waveshaper: clock, reset, stimulus and verdict.
module tb
    import asw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TANH_BITS   = 8;
    localparam int RAND_PHASES = 16;
    localparam int PHASE_ITEMS = 90;
    localparam int IDLE_PCT    = 23;
    localparam int TAIL_CYCLES = 40;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end_in;
    logic                       done;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end_out;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int   pending;
    int   fails;
    int   results;
    int   n_items;
    int   n_settings;
    logic steady;

    audio_saturation_waveshaper #(.TANH_TABLE_BITS(TANH_BITS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_in    (sample_in),
        .block_end_in (block_end_in),
        .done         (done),
        .sample_out   (sample_out),
        .block_end_out(block_end_out),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    asw_shape_checker #(.TABLE_BITS(TANH_BITS)) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_in    (sample_in),
        .block_end_in (block_end_in),
        .done         (done),
        .sample_out   (sample_out),
        .block_end_out(block_end_out),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .fails        (fails),
        .results      (results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results still pending", pending);
        $display("** audio_saturation_waveshaper: FAILED **");
        $finish;
    end

    // write all four registers; junk above the mix, mode and enable widths must be dropped
    task automatic load_regs(input logic [GAIN_W-1:0] gain, input logic [MIX_W-1:0] mix,
                             input mode_t mode, input logic en);
        cfg_write <= 1'b1;
        cfg_index <= CFG_DRIVE;
        cfg_data <= gain;
        @(posedge clk);
        cfg_index <= CFG_MIX;
        cfg_data <= {17'($urandom), mix};
        @(posedge clk);
        cfg_index <= CFG_MODE;
        cfg_data <= {22'($urandom), mode};
        @(posedge clk);
        cfg_index <= CFG_ENABLE;
        cfg_data <= {23'($urandom), en};
        @(posedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic blk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        sample_in <= s;
        block_end_in <= blk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_items++;
    endtask

    // stop sending and hold until every item has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = SAMPLE_MAX;
                    1:       v = Q23_ONE;
                    2:       v = '0;
                    3:       v = 24'd1;
                    default: v = '1;
                endcase
            end
            1, 2:
            begin
                v = 24'($urandom_range(0, 4095));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = 24'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return 24'($urandom_range(0, 32768));
            6, 7, 8:    return 24'($urandom_range(32768, 262144));
            default:    return 24'($urandom);
        endcase
    endfunction

    function automatic logic [MIX_W-1:0] pick_mix();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return MIX_FULL;
            2:       return 7'($urandom_range(101, 127));
            default: return 7'($urandom_range(0, 100));
        endcase
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        sample_in = '0;
        block_end_in = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_DRIVE;
        cfg_data = '0;
        steady = 1'b0;
        n_items = 0;
        n_settings = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: tanh, unity drive, fully wet
        push_sample('0, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(Q23_ONE, 1'b0);
        push_sample(24'd1, 1'b1);
        push_sample('1, 1'b0);
        drain();

        load_regs('1, MIX_FULL, MODE_SOFT, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(Q23_ONE, 1'b1);
        push_sample(24'd12345, 1'b0);
        drain();

        // wet share above 100 must clamp
        load_regs(24'd65536, 7'd127, MODE_HARD, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(-24'sd5000000, 1'b0);
        push_sample(24'd3000000, 1'b1);
        drain();

        // drive far past the table span, spare mode code
        load_regs('1, 7'd50, MODE_TANH_ALT, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample('1, 1'b1);
        push_sample(24'd100, 1'b0);
        drain();

        // zero drive leaves only the dry share
        load_regs('0, 7'd30, MODE_SOFT, 1'b1);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(Q23_ONE, 1'b0);
        drain();

        // bypass
        load_regs(24'd32768, '0, MODE_HARD, 1'b0);
        push_sample(Q23_ONE, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(24'd7, 1'b1);
        drain();

        load_regs(24'd32768, '0, MODE_TANH, 1'b1);
        push_sample(Q23_ONE, 1'b0);
        push_sample(SAMPLE_MAX, 1'b1);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            load_regs(pick_gain(), pick_mix(), mode_t'($urandom_range(0, 3)),
                      $urandom_range(0, 99) < 85);
            steady = (ph % 5 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_sample(pick_sample(), $urandom_range(0, 7) == 0);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d samples under %0d register settings; %0d results checked, %0d errors",
                 n_items, n_settings, results, fails);
        $display("Covered all shaper modes, bypass, zero and full-scale drive, wet share 0..127");
        if (fails == 0)
            $display("** audio_saturation_waveshaper: PASSED **");
        else
            $display("** audio_saturation_waveshaper: FAILED **");
        $finish;
    end

endmodule

### sim.f
hdl/asw_pkg.sv
hdl/asw_div.sv
hdl/asw_shape.sv
hdl/audio_saturation_waveshaper.sv
test/asw_shape_checker.sv
test/tb.sv
